// File: hdl/lewp_pkg.sv
package lewp_pkg;

   localparam int COORD_W = 8;
   localparam int DIR_W   = 2;
   localparam int INDEX_W = 6;
   localparam int ACT_W   = 3;
   localparam int LEN_W   = 7;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_SET   = 3'd0,
      ACT_CLEAR = 3'd1,
      ACT_SAME  = 3'd2,
      ACT_FULL  = 3'd3,
      ACT_READ  = 3'd4
   } act_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      act_type            mark_action;
      logic [DIR_W-1:0]   out_dir;
      logic [LEN_W-1:0]   path_length;
      logic               loop_erased;
      logic               last;
   } rsp_word_type;

endpackage

// File: hdl/lewp_if.sv
interface lewp_req_if;
   logic                                valid;
   logic                                ready;
   lewp_pkg::op_type                    op;
   logic [lewp_pkg::COORD_W-1:0]        cell_x;
   logic [lewp_pkg::COORD_W-1:0]        cell_y;
   logic [lewp_pkg::DIR_W-1:0]          step_dir;
   logic [lewp_pkg::INDEX_W-1:0]        read_index;

   modport source (output valid, op, cell_x, cell_y, step_dir, read_index, input ready);
   modport sink (input valid, op, cell_x, cell_y, step_dir, read_index, output ready);
endinterface

interface lewp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lewp_pkg::COORD_W-1:0]        out_x;
   logic [lewp_pkg::COORD_W-1:0]        out_y;
   lewp_pkg::act_type                   mark_action;
   logic [lewp_pkg::DIR_W-1:0]          out_dir;
   logic [lewp_pkg::LEN_W-1:0]          path_length;
   logic                                loop_erased;
   logic                                last;

   modport source (output valid, out_x, out_y, mark_action, out_dir, path_length,
                   loop_erased, last, input ready);
   modport sink (input valid, out_x, out_y, mark_action, out_dir, path_length,
                 loop_erased, last, output ready);
endinterface

// File: hdl/loop_erased_walk_path.sv
// Loop-erased walk path keeper.
// req_ch carries one item: an add (cell and step direction) or a read of a path
// entry. rsp_ch returns result items; the final one of an item has last set.
// An add searches the path one entry per cycle through the path memory's read
// port, then appends the cell (set mark), drops it when the path is full, or
// cuts the path back to the matching entry and gives one clear-mark item per
// erased entry (no-change when nothing was erased).
// A read makes one path memory read before its result. An add reads the path
// entries up to the match, or all of them on a miss, before its first result,
// and each further clear-mark item needs a memory read of its own, as the path
// memory has a single read port. Worst case is a hit on the first entry of a
// full path of 64 entries, which gives 63 clear-mark items.
// req_ch.ready is high only between items. A finished result waits in the
// output register; a stalled receiver holds the sequencer until it is taken.
// Reset is synchronous: it empties the path and drops any pending result. The
// path memory is not cleared; entries at or beyond the path length are never
// returned.
module loop_erased_walk_path #(
   parameter int PATH_DEPTH = 64,
   parameter int COORD_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   lewp_req_if.sink          req_ch,
   lewp_rsp_if.source        rsp_ch
);

   import lewp_pkg::*;

   localparam int SW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int AW = $clog2(PATH_DEPTH);
   localparam int CW = $clog2(PATH_DEPTH + 1);
   localparam int DW = 2 * SW + DIR_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SEARCH    = 5'b00010,
      ST_CLR_ISSUE = 5'b00100,
      ST_CLR_OUT   = 5'b01000,
      ST_SINGLE    = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    addr_ff, addr_in;
   logic [CW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]    end_ff, end_in;
   logic [SW-1:0]    cx_ff, cx_in;
   logic [SW-1:0]    cy_ff, cy_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic             rd_ok_ff, rd_ok_in;
   act_type          act_ff, act_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [DW-1:0]    wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [DW-1:0]    rd_data;

   logic [SW-1:0]    rd_x;
   logic [SW-1:0]    rd_y;
   logic [DIR_W-1:0] rd_d;
   logic             match;
   logic             out_free;
   logic             clr_last;

   lewp_ram #(
      .WIDTH (DW),
      .DEPTH (PATH_DEPTH)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x     = rd_data[DW-1 -: SW];
   assign rd_y     = rd_data[DIR_W +: SW];
   assign rd_d     = rd_data[DIR_W-1:0];
   assign match    = cmp_vld_ff && (rd_x == cx_ff) && (rd_y == cy_ff);
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign clr_last = ((addr_ff + CW'(1)) == end_ff);

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.out_x       = rsp_ff.out_x;
   assign rsp_ch.out_y       = rsp_ff.out_y;
   assign rsp_ch.mark_action = rsp_ff.mark_action;
   assign rsp_ch.out_dir     = rsp_ff.out_dir;
   assign rsp_ch.path_length = rsp_ff.path_length;
   assign rsp_ch.loop_erased = rsp_ff.loop_erased;
   assign rsp_ch.last        = rsp_ff.last;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      end_in     = end_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      dir_in     = dir_ff;
      rd_ok_in   = rd_ok_ff;
      act_in     = act_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = {cx_ff, cy_ff, dir_ff};
      rd_en      = 1'b0;
      rd_addr    = addr_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cx_in  = req_ch.cell_x[SW-1:0];
               cy_in  = req_ch.cell_y[SW-1:0];
               dir_in = req_ch.step_dir;
               if (req_ch.op == OP_READ) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_ch.read_index[AW-1:0];
                  rd_ok_in = LEN_W'(req_ch.read_index) < LEN_W'(count_ff);
                  act_in   = ACT_READ;
                  state_in = ST_SINGLE;
               end else begin
                  addr_in    = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmp_vld_in = 1'b0;
            if (match) begin
               wr_en    = 1'b1;
               wr_addr  = cmp_idx_ff[AW-1:0];
               count_in = cmp_idx_ff + CW'(1);
               end_in   = count_ff;
               addr_in  = cmp_idx_ff + CW'(1);
               if ((cmp_idx_ff + CW'(1)) < count_ff) begin
                  state_in = ST_CLR_ISSUE;
               end else begin
                  act_in   = ACT_SAME;
                  state_in = ST_SINGLE;
               end
            end else if (addr_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = addr_ff[AW-1:0];
               addr_in    = addr_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = addr_ff;
            end else if (!cmp_vld_ff) begin
               if (count_ff == DEPTH_C) begin
                  act_in = ACT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  act_in   = ACT_SET;
               end
               state_in = ST_SINGLE;
            end
         end
         ST_CLR_ISSUE: begin
            rd_en    = 1'b1;
            state_in = ST_CLR_OUT;
         end
         ST_CLR_OUT: begin
            if (out_free) begin
               rsp_vld_in             = 1'b1;
               rsp_in.out_x           = COORD_W'(rd_x);
               rsp_in.out_y           = COORD_W'(rd_y);
               rsp_in.mark_action     = ACT_CLEAR;
               rsp_in.out_dir         = '0;
               rsp_in.path_length     = LEN_W'(count_ff);
               rsp_in.loop_erased     = 1'b1;
               rsp_in.last            = clr_last;
               addr_in                = addr_ff + CW'(1);
               state_in               = clr_last ? ST_IDLE : ST_CLR_ISSUE;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_vld_in         = 1'b1;
               rsp_in.mark_action = act_ff;
               rsp_in.path_length = LEN_W'(count_ff);
               rsp_in.loop_erased = (act_ff == ACT_SAME);
               rsp_in.last        = 1'b1;
               if (act_ff == ACT_READ) begin
                  rsp_in.out_x   = rd_ok_ff ? COORD_W'(rd_x) : '0;
                  rsp_in.out_y   = rd_ok_ff ? COORD_W'(rd_y) : '0;
                  rsp_in.out_dir = rd_ok_ff ? rd_d : '0;
               end else begin
                  rsp_in.out_x   = COORD_W'(cx_ff);
                  rsp_in.out_y   = COORD_W'(cy_ff);
                  rsp_in.out_dir = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cmp_idx_ff <= cmp_idx_in;
      end_ff     <= end_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      dir_ff     <= dir_in;
      rd_ok_ff   <= rd_ok_in;
      act_ff     <= act_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: hdl/lewp_ram.sv
module lewp_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
